[src/irps_pkg.sv]
// ----------------------------------------------------------------------------
// irps_pkg
// Types, codes and field layout shared by the infrared sensor poll sequencer.
// ----------------------------------------------------------------------------
package irps_pkg;

    // Input beat layout (s_tdata), lowest bit first.
    localparam int RX_FIRST_LSB  = 0;
    localparam int RX_SECOND_LSB = 8;
    localparam int RX_STATUS_LSB = 16;
    localparam int WAS_READ_BIT  = 24;
    localparam int IN_DATA_W     = 32;

    // Output beat layout (m_tdata), lowest bit first.
    localparam int OUT_FIELDS_W  = 69;
    localparam int OUT_DATA_W    = 72;

    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_RESOLUTION    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SETUP_ENABLE  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LEFT_NEUTRAL  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_NEUTRAL = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP_NEUTRAL   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_PUBLISH_EN    = 3'd5;

    // Bytes sent to the converters.
    localparam logic [7:0] VER_OC_MASK     = 8'h10;
    localparam logic [7:0] SELECT_TWO_MASK = 8'h20;
    localparam logic [7:0] START_CONV_MASK = 8'h80;
    localparam int         NOT_READY_BIT   = 7;

    // Filter arithmetic: numerator magnitude stays below 2^19.
    localparam int NUM_W     = 20;
    localparam int MAG_W     = NUM_W - 1;
    localparam int DIV_STEPS = MAG_W;
    localparam int STEP_W    = 5;

    typedef enum logic [1:0] {
        OP_POLL     = 2'd0,
        OP_HOR_DONE = 2'd1,
        OP_VER_DONE = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_NONE  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } command_t;

    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_READ_ONE     = 3'd1,
        PH_TWO_SELECTED = 3'd2,
        PH_READ_TWO     = 3'd3,
        PH_ONE_SELECTED = 3'd4,
        PH_CONFIGURE    = 3'd5
    } hor_phase_t;

    typedef enum logic [1:0] {
        SLOT_LEFT  = 2'd0,
        SLOT_RIGHT = 2'd1,
        SLOT_TOP   = 2'd2
    } slot_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_COMMIT,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0]         resolution;
        logic               setup_enable;
        logic signed [15:0] left_neutral;
        logic signed [15:0] right_neutral;
        logic signed [15:0] top_neutral;
        logic               publish_enable;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        slot_t      slot;
        logic       prep;
        logic       step;
        logic       commit;
        logic       out_load;
        command_t   hor_command;
        logic [7:0] hor_write_byte;
        command_t   ver_command;
        logic [7:0] ver_write_byte;
        logic       publish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

[src/irps_ctrl.sv]
// ----------------------------------------------------------------------------
// irps_ctrl
// Poll and phase state machine, and sequencing of the filter datapath.
// ----------------------------------------------------------------------------
module irps_ctrl
    import irps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] opcode,
    input  logic [7:0] rx_status,
    input  logic       was_read,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    ctrl_state_t      state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    hor_phase_t       phase_reg, phase_next;
    logic             hor_busy_reg, hor_busy_next;
    logic             ver_busy_reg, ver_busy_next;
    logic             hor_setup_reg, hor_setup_next;
    logic             ver_setup_reg, ver_setup_next;
    logic             hor_fresh_reg, hor_fresh_next;
    logic             ver_fresh_reg, ver_fresh_next;

    command_t   hcmd_reg, hcmd_next;
    logic [7:0] hbyte_reg, hbyte_next;
    command_t   vcmd_reg, vcmd_next;
    logic [7:0] vbyte_reg, vbyte_next;
    logic       pub_reg, pub_next;
    slot_t      slot_reg, slot_next;

    logic       accept;
    logic       filter;
    logic [7:0] k_byte;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign k_byte   = {6'd0, cfg.resolution};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            phase_reg     <= PH_IDLE;
            hor_busy_reg  <= 1'b0;
            ver_busy_reg  <= 1'b0;
            hor_setup_reg <= 1'b0;
            ver_setup_reg <= 1'b0;
            hor_fresh_reg <= 1'b0;
            ver_fresh_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            phase_reg     <= phase_next;
            hor_busy_reg  <= hor_busy_next;
            ver_busy_reg  <= ver_busy_next;
            hor_setup_reg <= hor_setup_next;
            ver_setup_reg <= ver_setup_next;
            hor_fresh_reg <= hor_fresh_next;
            ver_fresh_reg <= ver_fresh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hcmd_reg  <= hcmd_next;
        hbyte_reg <= hbyte_next;
        vcmd_reg  <= vcmd_next;
        vbyte_reg <= vbyte_next;
        pub_reg   <= pub_next;
        slot_reg  <= slot_next;
    end

    // Event decoding: all protocol decisions are taken in the accept cycle.
    always_comb
    begin
        phase_next     = phase_reg;
        hor_busy_next  = hor_busy_reg;
        ver_busy_next  = ver_busy_reg;
        hor_setup_next = hor_setup_reg;
        ver_setup_next = ver_setup_reg;
        hor_fresh_next = hor_fresh_reg;
        ver_fresh_next = ver_fresh_reg;
        hcmd_next      = hcmd_reg;
        hbyte_next     = hbyte_reg;
        vcmd_next      = vcmd_reg;
        vbyte_next     = vbyte_reg;
        pub_next       = pub_reg;
        slot_next      = slot_reg;
        filter         = 1'b0;

        if (accept)
        begin
            hcmd_next  = CMD_NONE;
            hbyte_next = '0;
            vcmd_next  = CMD_NONE;
            vbyte_next = '0;
            pub_next   = 1'b0;
            unique case (opcode)
                OP_POLL:
                begin
                    if (!hor_busy_reg && phase_reg == PH_IDLE)
                    begin
                        if (cfg.setup_enable && !hor_setup_reg)
                        begin
                            hcmd_next  = CMD_WRITE;
                            hbyte_next = k_byte | START_CONV_MASK;
                            phase_next = PH_CONFIGURE;
                        end
                        else
                        begin
                            hcmd_next      = CMD_READ;
                            hor_fresh_next = 1'b0;
                            phase_next     = PH_READ_ONE;
                        end
                        hor_busy_next = 1'b1;
                    end
                    if (!ver_busy_reg)
                    begin
                        if (cfg.setup_enable && !ver_setup_reg)
                        begin
                            vcmd_next  = CMD_WRITE;
                            vbyte_next = k_byte | VER_OC_MASK;
                        end
                        else
                        begin
                            vcmd_next      = CMD_READ;
                            ver_fresh_next = 1'b0;
                        end
                        ver_busy_next = 1'b1;
                    end
                end
                OP_HOR_DONE:
                begin
                    hor_busy_next = 1'b0;
                    unique case (phase_reg)
                        PH_READ_ONE:
                        begin
                            if (rx_status[NOT_READY_BIT])
                            begin
                                hcmd_next = CMD_READ;
                            end
                            else
                            begin
                                filter     = 1'b1;
                                slot_next  = SLOT_LEFT;
                                hcmd_next  = CMD_WRITE;
                                hbyte_next = k_byte | SELECT_TWO_MASK | START_CONV_MASK;
                                phase_next = PH_TWO_SELECTED;
                            end
                            hor_busy_next = 1'b1;
                        end
                        PH_TWO_SELECTED:
                        begin
                            hcmd_next     = CMD_READ;
                            hor_busy_next = 1'b1;
                            phase_next    = PH_READ_TWO;
                        end
                        PH_READ_TWO:
                        begin
                            if (rx_status[NOT_READY_BIT])
                            begin
                                hcmd_next = CMD_READ;
                            end
                            else
                            begin
                                filter         = 1'b1;
                                slot_next      = SLOT_RIGHT;
                                hor_fresh_next = 1'b1;
                                if (cfg.publish_enable && ver_fresh_reg)
                                begin
                                    pub_next       = 1'b1;
                                    hor_fresh_next = 1'b0;
                                    ver_fresh_next = 1'b0;
                                end
                                hcmd_next  = CMD_WRITE;
                                hbyte_next = k_byte | START_CONV_MASK;
                                phase_next = PH_ONE_SELECTED;
                            end
                            hor_busy_next = 1'b1;
                        end
                        PH_CONFIGURE:
                        begin
                            hor_setup_next = 1'b1;
                            phase_next     = PH_IDLE;
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
                OP_VER_DONE:
                begin
                    ver_busy_next = 1'b0;
                    if (was_read)
                    begin
                        filter         = 1'b1;
                        slot_next      = SLOT_TOP;
                        ver_fresh_next = 1'b1;
                        if (cfg.publish_enable && hor_fresh_reg)
                        begin
                            pub_next       = 1'b1;
                            hor_fresh_next = 1'b0;
                            ver_fresh_next = 1'b0;
                        end
                    end
                    else
                    begin
                        ver_setup_next = 1'b1;
                    end
                end
                default:
                begin
                    // Unused opcode: nothing changes, no commands.
                end
            endcase
        end
    end

    // Sequencer for the filter datapath and the result register.
    always_comb
    begin
        state_next         = state_reg;
        step_next          = step_reg;
        cmd                = '0;
        cmd.slot           = slot_reg;
        cmd.hor_command    = hcmd_reg;
        cmd.hor_write_byte = hbyte_reg;
        cmd.ver_command    = vcmd_reg;
        cmd.ver_write_byte = vbyte_reg;
        cmd.publish        = pub_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = filter;
                    cmd.slot   = slot_next;
                    state_next = filter ? ST_PREP : ST_DONE;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step  = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[src/irps_dp.sv]
// ----------------------------------------------------------------------------
// irps_dp
// Offset, recursive filter with a bit-serial divider, and the result register.
// ----------------------------------------------------------------------------
module irps_dp
    import irps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cfg_t                  cfg,
    input  logic [7:0]            rx_first,
    input  logic [7:0]            rx_second,
    input  dp_cmd_t               cmd,
    output dp_status_t            status,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic [15:0]       filt_reg [3];
    logic [15:0]       sample_reg;
    slot_t             slot_reg;
    logic [MAG_W-1:0]  quo_reg;
    logic [3:0]        rem_reg;
    logic              neg_reg;
    logic              valid_reg;
    logic [OUT_DATA_W-1:0] data_reg;

    logic [15:0]       neutral_sel;
    logic [15:0]       neutral_sh;
    logic [15:0]       prev;
    logic [NUM_W-1:0]  num;
    logic [NUM_W-1:0]  mag;
    logic [4:0]        divisor;
    logic [4:0]        trial;
    logic              fits;
    logic [MAG_W-1:0]  quotient;

    always_comb
    begin
        unique case (cmd.slot)
            SLOT_LEFT:  neutral_sel = cfg.left_neutral;
            SLOT_RIGHT: neutral_sel = cfg.right_neutral;
            default:    neutral_sel = cfg.top_neutral;
        endcase
    end

    // The scaled neutral wraps to 16 bits, as does the difference.
    assign neutral_sh = neutral_sel << cfg.resolution;
    assign prev       = filt_reg[slot_reg];
    assign num        = ({{(NUM_W-16){prev[15]}}, prev} << cfg.resolution)
                      + {{(NUM_W-16){sample_reg[15]}}, sample_reg};
    assign mag        = num[NUM_W-1] ? (~num + 1'b1) : num;

    assign divisor  = (5'd1 << cfg.resolution) + 5'd1;
    assign trial    = {rem_reg, quo_reg[MAG_W-1]};
    assign fits     = (trial >= divisor);
    assign quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= {rx_first, rx_second} - neutral_sh;
            slot_reg   <= cmd.slot;
        end
        if (cmd.prep)
        begin
            quo_reg <= mag[MAG_W-1:0];
            rem_reg <= '0;
            neg_reg <= num[NUM_W-1];
        end
        else if (cmd.step)
        begin
            rem_reg <= fits ? 4'(trial - divisor) : trial[3:0];
            quo_reg <= {quo_reg[MAG_W-2:0], fits};
        end
        if (cmd.out_load)
        begin
            data_reg <= {
                {(OUT_DATA_W-OUT_FIELDS_W){1'b0}},
                filt_reg[SLOT_TOP],
                filt_reg[SLOT_RIGHT],
                filt_reg[SLOT_LEFT],
                cmd.publish,
                cmd.ver_write_byte,
                cmd.ver_command,
                cmd.hor_write_byte,
                cmd.hor_command
            };
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg[0] <= '0;
            filt_reg[1] <= '0;
            filt_reg[2] <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                filt_reg[slot_reg] <= quotient[15:0];
            end
            if (cmd.out_load)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign status.out_free = !valid_reg || m_tready;
    assign m_tvalid        = valid_reg;
    assign m_tdata         = data_reg;

endmodule

[src/ir_sensor_poll_sequencer.sv]
// ----------------------------------------------------------------------------
// ir_sensor_poll_sequencer
// Poll sequencer for a two-channel horizontal and a single vertical IR ADC.
// ----------------------------------------------------------------------------
// Usage:
// Events enter on the s_ beat channel: tuser carries the opcode (poll tick,
// horizontal done, vertical done) and tdata the received bytes. Each accepted
// beat yields exactly one m_ beat with the commands for both links, the
// publish strobe and the three current filtered values.
// An event that does not filter a sample is decoded in the accept cycle
// and then loaded into the result register. An event that filters goes
// through these steps in order: offset the sample, form the filter
// numerator, 19 steps of the one-bit-a-cycle divider, write the filter
// state back, and load the result. One event is worked on at a time, so
// a new event is taken only after the last one has loaded its result.
// s_tready is high whenever the sequencer is idle, also while a finished
// result still waits in the output register.
// If the receiver stalls, the result stays in the output register and the
// next event waits at the end of its work until the register frees up.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Reset clears the phase machine, all flags and filtered values, and loads
// the registers with their defaults (setup and publish enabled).
// ----------------------------------------------------------------------------
module ir_sensor_poll_sequencer
    import irps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // opcode[1:0]
    input  logic [1:0]             s_tuser,
    // rx_first[7:0], rx_second[15:8], rx_status[23:16], vertical_was_read[24]
    input  logic [IN_DATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // hor_command[1:0], hor_write_byte[9:2], ver_command[11:10],
    // ver_write_byte[19:12], publish[20], left_value[36:21],
    // right_value[52:37], top_value[68:53]
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    cfg_t       cfg_reg;
    dp_cmd_t    cmd;
    dp_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.resolution     <= 2'd0;
            cfg_reg.setup_enable   <= 1'b1;
            cfg_reg.left_neutral   <= '0;
            cfg_reg.right_neutral  <= '0;
            cfg_reg.top_neutral    <= '0;
            cfg_reg.publish_enable <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RESOLUTION:    cfg_reg.resolution     <= cfg_data[1:0];
                REG_SETUP_ENABLE:  cfg_reg.setup_enable   <= cfg_data[0];
                REG_LEFT_NEUTRAL:  cfg_reg.left_neutral   <= cfg_data;
                REG_RIGHT_NEUTRAL: cfg_reg.right_neutral  <= cfg_data;
                REG_TOP_NEUTRAL:   cfg_reg.top_neutral    <= cfg_data;
                REG_PUBLISH_EN:    cfg_reg.publish_enable <= cfg_data[0];
                default:
                begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    irps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .opcode    (s_tuser),
        .rx_status (s_tdata[RX_STATUS_LSB +: 8]),
        .was_read  (s_tdata[WAS_READ_BIT]),
        .cmd       (cmd),
        .status    (status)
    );

    irps_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .rx_first  (s_tdata[RX_FIRST_LSB +: 8]),
        .rx_second (s_tdata[RX_SECOND_LSB +: 8]),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[src/irps_chk.sv]
// ----------------------------------------------------------------------------
// irps_chk
// Port-level checks on the poll sequencer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module irps_chk
    import irps_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A result beat that is not taken stays as it is.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // One event is worked on at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while an event is in progress");

    // The horizontal command code never takes the unused value.
    a_hor_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("invalid horizontal command");

    // Write bytes are zero unless the matching command is a write.
    a_write_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] == CMD_WRITE || m_tdata[9:2] == 8'd0)
                  && (m_tdata[11:10] == CMD_WRITE || m_tdata[19:12] == 8'd0))
        else $error("write byte without a write command");

endmodule

bind ir_sensor_poll_sequencer irps_chk u_irps_chk (.*);
